FILE: rtl/core/vfpc_pkg.sv
// Shared constants, types and helpers for the vsync field period calculator.
package vfpc_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CH_W         = 3;

  localparam int CLK_W        = 25;
  localparam logic [CLK_W-1:0] CLOCK_HZ = CLK_W'(27000000);
  localparam int WORD_W       = 32;
  localparam int PROD_W       = CLK_W + WORD_W;
  localparam int DIV_CNT_W    = $clog2(PROD_W + 1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAN = 2'd1,
    STATUS_ZERO_ARG = 2'd2
  } status_t;

  typedef enum logic {
    KIND_SET_SHIFT = 1'b0,
    KIND_SET_FIELD = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } fsm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic                shift_we;
    logic                intl_we;
    logic [CH_IDX_W-1:0] idx;
    logic [WORD_W-1:0]   shift_val;
    logic                intl_val;
  } store_wr_t;

  function automatic logic chan_ok(input logic [CH_W-1:0] ch);
    return {1'b0, ch} < (CH_W + 1)'(NUM_CHANNELS);
  endfunction

endpackage

FILE: rtl/core/vfpc_ifs.sv
// Handshake channel interfaces: request, response and configuration write.
interface vfpc_req_if;
  import vfpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [CH_W-1:0]          channel;
  logic [WORD_W-1:0]        rate_residual;
  logic [WORD_W-1:0]        rate_divider;
  logic                     want_interlaced;
  logic signed [WORD_W-1:0] shift_delta;

  modport source (output valid, kind, channel, rate_residual, rate_divider,
                  want_interlaced, shift_delta, input ready);
  modport sink   (input valid, kind, channel, rate_residual, rate_divider,
                  want_interlaced, shift_delta, output ready);
endinterface

interface vfpc_rsp_if;
  import vfpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [30:0]       field0_count;
  logic [WORD_W-1:0] field1_count;
  logic              periods_valid;
  logic              scan_mode_write;
  logic              scan_interlaced;

  modport source (output valid, status, field0_count, field1_count, periods_valid,
                  scan_mode_write, scan_interlaced, input ready);
  modport sink   (input valid, status, field0_count, field1_count, periods_valid,
                  scan_mode_write, scan_interlaced, output ready);
endinterface

interface vfpc_cfg_if;
  logic valid;
  logic ready;
  logic shift_disable;

  modport source (output valid, shift_disable, input ready);
  modport sink   (input valid, shift_disable, output ready);
endinterface

FILE: rtl/core/vfpc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, low word of quotient kept.
module vfpc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vfpc_pkg::PROD_W-1:0]   dividend,
  input  logic [vfpc_pkg::WORD_W-1:0]   divisor,
  output vfpc_pkg::div_stat_t           stat,
  output logic [vfpc_pkg::WORD_W-1:0]   quotient
);
  import vfpc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    dvd;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    dsr;
  logic [WORD_W-1:0]    quo;

  logic [WORD_W:0]      rem_sh;
  logic [WORD_W+1:0]    diff;
  logic                 q_bit;

  // Remainder stays below the divisor, so the shifted value fits WORD_W+1 bits.
  always_comb begin
    rem_sh = {rem, dvd[PROD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr};
    q_bit  = ~diff[WORD_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(PROD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[PROD_W-2:0], 1'b0};
      rem <= q_bit ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quo <= {quo[WORD_W-2:0], q_bit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

FILE: rtl/core/vfpc_store.sv
// Per-channel phase shift and current scan type registers.
module vfpc_store (
  input  logic                            clk,
  input  logic                            rst,
  input  vfpc_pkg::store_wr_t             wr,
  input  logic [vfpc_pkg::CH_IDX_W-1:0]   rd_idx,
  output logic [vfpc_pkg::WORD_W-1:0]     shift_rd,
  output logic                            intl_rd
);
  import vfpc_pkg::*;

  logic [WORD_W-1:0]       phase_shift [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] cur_interlaced;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase_shift[i] <= '0;
      end
      cur_interlaced <= '1;
    end else begin
      if (wr.shift_we) begin
        phase_shift[wr.idx] <= wr.shift_val;
      end
      if (wr.intl_we) begin
        cur_interlaced[wr.idx] <= wr.intl_val;
      end
    end
  end

  assign shift_rd = phase_shift[rd_idx];
  assign intl_rd  = cur_interlaced[rd_idx];

endmodule

FILE: rtl/core/vsync_field_period_calc.sv
// Top level of the vsync field period calculator: sequencer, result register, config.
//
//   channel | role      | transaction carries
//   --------+-----------+----------------------------------------------------------
//   cfg     | sink      | shift_disable
//   req     | sink      | kind, channel, rate_residual, rate_divider,
//           |           | want_interlaced, shift_delta
//   rsp     | source    | status, field0_count, field1_count, periods_valid,
//           |           | scan_mode_write, scan_interlaced
//
// A set_shift transaction, a bad channel or a zero residual/divider goes from IDLE
// straight to DONE. A set_field goes through IDLE (latch), MUL (start the divider on
// the 25x32 constant product), DIV (the bit-serial divider, one quotient bit per cycle
// over the 57-bit product, until done) and DONE (result assembly). DONE loads the
// result and frees req once the response register is free.
// One request is in flight at a time; req.ready is high only while idle, and a
// result may sit in the response register while the next request is accepted.
// Reset (rst, synchronous) clears shift_disable, all phase shifts to zero and all
// scan types to interlaced. A stalled rsp holds the finished result in the sequencer.
module vsync_field_period_calc (
  input logic       clk,
  input logic       rst,
  vfpc_cfg_if.sink  cfg,
  vfpc_req_if.sink  req,
  vfpc_rsp_if.source rsp
);
  import vfpc_pkg::*;

  // Configuration register; always writable.
  logic shift_disable;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_disable <= 1'b0;
    end else if (cfg.valid) begin
      shift_disable <= cfg.shift_disable;
    end
  end

  // Sequencer state and latched request.
  fsm_state_t state;
  fsm_state_t state_next;

  logic              in_kind;
  logic [CH_W-1:0]   in_ch;
  logic [WORD_W-1:0] in_res;
  logic [WORD_W-1:0] in_div;
  logic              in_want;
  logic [WORD_W-1:0] in_delta;

  logic accept;
  logic div_start;
  logic load;
  logic req_needs_div;

  div_stat_t         div_stat;
  logic [WORD_W-1:0] quotient;
  logic [PROD_W-1:0] product;

  // Response register.
  logic              out_valid;
  status_t           out_status;
  logic [30:0]       out_f0;
  logic [WORD_W-1:0] out_f1;
  logic              out_pv;
  logic              out_mw;
  logic              out_intl;

  // Result assembly from the latched request.
  logic              ch_good;
  logic              args_zero;
  logic              periods_ok;
  status_t           res_status;
  logic [WORD_W-1:0] shift_rd;
  logic              intl_rd;
  logic [WORD_W-1:0] total;
  logic [30:0]       f0;
  logic [WORD_W-1:0] f1;
  store_wr_t         store_wr;

  // Route a request to the divider only when it can produce periods.
  assign req_needs_div = (req.kind == KIND_SET_FIELD) && chan_ok(req.channel) &&
                         (req.rate_residual != '0) && (req.rate_divider != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = req_needs_div ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    accept    = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state)
      ST_IDLE: accept    = req.valid;
      ST_MUL:  div_start = 1'b1;
      ST_DIV:  ;
      ST_DONE: load      = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request payload for the whole computation.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind  <= req.kind;
      in_ch    <= req.channel;
      in_res   <= req.rate_residual;
      in_div   <= req.rate_divider;
      in_want  <= req.want_interlaced;
      in_delta <= req.shift_delta;
    end
  end

  // Clock product; the divider registers it on start.
  assign product = PROD_W'(CLOCK_HZ) * PROD_W'(in_div);

  vfpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (in_res),
    .stat     (div_stat),
    .quotient (quotient)
  );

  vfpc_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (store_wr),
    .rd_idx   (in_ch[CH_IDX_W-1:0]),
    .shift_rd (shift_rd),
    .intl_rd  (intl_rd)
  );

  always_comb begin
    ch_good    = chan_ok(in_ch);
    args_zero  = (in_res == '0) || (in_div == '0);
    periods_ok = ch_good && (in_kind == KIND_SET_FIELD) && !args_zero;

    priority if (!ch_good) begin
      res_status = STATUS_BAD_CHAN;
    end else if ((in_kind == KIND_SET_FIELD) && args_zero) begin
      res_status = STATUS_ZERO_ARG;
    end else begin
      res_status = STATUS_OK;
    end

    // Quotient is already truncated to the low word; add the shift modulo 2^32.
    total = quotient + shift_rd;
    f0    = total[WORD_W-1:1];
    f1    = total - {1'b0, f0};

    store_wr.idx       = in_ch[CH_IDX_W-1:0];
    store_wr.shift_we  = load && ch_good && (in_kind == KIND_SET_SHIFT);
    store_wr.shift_val = shift_disable ? '0 : in_delta;
    store_wr.intl_we   = load && periods_ok;
    store_wr.intl_val  = in_want;
  end

  // Load the response register; drop valid once taken with nothing new behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= res_status;
      out_f0     <= periods_ok ? f0 : '0;
      out_f1     <= periods_ok ? f1 : '0;
      out_pv     <= periods_ok;
      out_mw     <= periods_ok && (in_want != intl_rd);
      out_intl   <= periods_ok && in_want;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.field0_count    = out_f0;
  assign rsp.field1_count    = out_f1;
  assign rsp.periods_valid   = out_pv;
  assign rsp.scan_mode_write = out_mw;
  assign rsp.scan_interlaced = out_intl;

endmodule

FILE: test/tb_vsync_field_period_calc.sv
`timescale 1ns / 100ps
// Testbench for vsync_field_period_calc: field period predictor, checker and stimulus.

package vsync_period_tb_pkg;
  import vfpc_pkg::*;

  localparam longint unsigned REF_CLOCK_HZ = 64'd27000000;

  typedef struct packed {
    kind_t             kind;
    logic [CH_W-1:0]   channel;
    logic [WORD_W-1:0] rate_residual;
    logic [WORD_W-1:0] rate_divider;
    logic              want_interlaced;
    logic [WORD_W-1:0] shift_delta;
  } field_request_t;

  typedef struct packed {
    status_t           status;
    logic [30:0]       field0;
    logic [WORD_W-1:0] field1;
    logic              periods_valid;
    logic              scan_mode_write;
    logic              scan_interlaced;
  } period_result_t;

  // Per-channel shift and scan-type predictor with a queue of expected responses.
  class field_period_predictor;
    bit                shift_disable;
    logic [WORD_W-1:0] phase_shift[NUM_CHANNELS];
    bit                cur_interlaced[NUM_CHANNELS];
    period_result_t    expected_periods[$];
    int                mismatches;

    function new();
      shift_disable = 1'b0;
      mismatches = 0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase_shift[i] = '0;
        cur_interlaced[i] = 1'b1;
      end
    endfunction

    function void set_shift_disable(bit value);
      shift_disable = value;
    endfunction

    function int pending();
      return expected_periods.size();
    endfunction

    function void note_request(field_request_t r);
      period_result_t    e;
      logic [63:0]       product;
      logic [WORD_W-1:0] total;
      int unsigned       ch;
      e = '0;
      e.status = STATUS_OK;
      ch = 32'(r.channel);
      if (r.channel >= NUM_CHANNELS) begin
        e.status = STATUS_BAD_CHAN;
      end else if (r.kind == KIND_SET_SHIFT) begin
        phase_shift[ch] = shift_disable ? '0 : r.shift_delta;
      end else if (r.rate_residual == '0 || r.rate_divider == '0) begin
        e.status = STATUS_ZERO_ARG;
      end else begin
        product = REF_CLOCK_HZ * 64'(r.rate_divider);
        total = 32'(product / 64'(r.rate_residual)) + phase_shift[ch];
        e.field0 = total[31:1];
        e.field1 = total - {1'b0, total[31:1]};
        e.periods_valid = 1'b1;
        e.scan_mode_write = (r.want_interlaced != cur_interlaced[ch]);
        e.scan_interlaced = r.want_interlaced;
        cur_interlaced[ch] = r.want_interlaced;
      end
      expected_periods.push_back(e);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_response(period_result_t got);
      period_result_t e;
      if (expected_periods.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response: expected none, actual %h", $time, got);
        return;
      end
      e = expected_periods.pop_front();
      compare_field("status", 32'(e.status), 32'(got.status));
      compare_field("field0_count", 32'(e.field0), 32'(got.field0));
      compare_field("field1_count", e.field1, got.field1);
      compare_field("periods_valid", 32'(e.periods_valid), 32'(got.periods_valid));
      compare_field("scan_mode_write", 32'(e.scan_mode_write), 32'(got.scan_mode_write));
      compare_field("scan_interlaced", 32'(e.scan_interlaced), 32'(got.scan_interlaced));
    endfunction
  endclass

endpackage

module tb_vsync_field_period_calc;
  import vfpc_pkg::*;
  import vsync_period_tb_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int TIMEOUT_CYCLES   = 1000000;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int RANDOM_PHASES    = 6;
  localparam int PHASE_ITEMS      = 240;
  // Leave margin after the last response.
  localparam int DRAIN_CYCLES     = 80;

  logic clk;
  logic rst;

  vfpc_cfg_if cfg_bus ();
  vfpc_req_if req_bus ();
  vfpc_rsp_if rsp_bus ();

  vsync_field_period_calc u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  field_period_predictor periods;

  // Long receiver hold-offs asked by the stimulus; the sink counts the ones it has served.
  int holds_asked;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: end the run if the block hangs or responses stop coming.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_vsync_field_period_calc failed");
    $finish;
  end

  function automatic field_request_t make_request(kind_t kind, int unsigned channel,
                                                  logic [31:0] residual, logic [31:0] divider,
                                                  bit want, logic [31:0] delta);
    field_request_t r;
    r.kind = kind;
    r.channel = channel[CH_W-1:0];
    r.rate_residual = residual;
    r.rate_divider = divider;
    r.want_interlaced = want;
    r.shift_delta = delta;
    return r;
  endfunction

  // Mix zero, all-ones, small values and single bits with full-range words.
  function automatic logic [31:0] random_operand();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel <= 5) return 32'($urandom_range(1, 4096));
    if (sel <= 7) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic field_request_t random_request();
    int unsigned sel;
    int unsigned channel;
    logic [31:0] delta;
    // Keep most traffic on live channels so the shift and scan state gets exercised.
    if ($urandom_range(0, 9) < 8) begin
      channel = $urandom_range(0, NUM_CHANNELS - 1);
    end else begin
      channel = $urandom_range(NUM_CHANNELS, (1 << CH_W) - 1);
    end
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      delta = 32'h8000_0000;
    end else if (sel == 1) begin
      delta = 32'h7FFF_FFFF;
    end else if (sel <= 5) begin
      delta = 32'($urandom_range(0, 2000)) - 32'd1000;
    end else begin
      delta = $urandom;
    end
    return make_request($urandom_range(0, 2) == 0 ? KIND_SET_SHIFT : KIND_SET_FIELD,
                        channel, random_operand(), random_operand(),
                        1'($urandom_range(0, 1)), delta);
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic offer(field_request_t r);
    req_bus.valid           <= 1'b1;
    req_bus.kind            <= r.kind;
    req_bus.channel         <= r.channel;
    req_bus.rate_residual   <= r.rate_residual;
    req_bus.rate_divider    <= r.rate_divider;
    req_bus.want_interlaced <= r.want_interlaced;
    req_bus.shift_delta     <= r.shift_delta;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    periods.note_request(r);
  endtask

  // Drop valid for a number of cycles; zero keeps the burst going.
  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drain every outstanding response, then write shift_disable while the block is idle.
  task automatic write_shift_disable(bit value);
    req_bus.valid <= 1'b0;
    while (periods.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.shift_disable <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    periods.set_shift_disable(value);
  endtask

  // Response sink: check every accepted transaction and stall on its own pattern.
  initial begin : response_sink
    period_result_t got;
    int             stall_left;
    int             hold_left;
    int             holds_done;
    int             mode;
    int             cyc;
    stall_left = 0;
    hold_left = 0;
    holds_done = 0;
    mode = 0;
    cyc = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready) begin
        got.status          = status_t'(rsp_bus.status);
        got.field0          = rsp_bus.field0_count;
        got.field1          = rsp_bus.field1_count;
        got.periods_valid   = rsp_bus.periods_valid;
        got.scan_mode_write = rsp_bus.scan_mode_write;
        got.scan_interlaced = rsp_bus.scan_interlaced;
        periods.check_response(got);
      end
      // Switch between always-ready, coin-flip and bursty stalls now and then.
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 2);
      if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            rsp_bus.ready <= 1'b1;
          end
          1: begin
            rsp_bus.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(0, 19);
              rsp_bus.ready <= 1'b0;
            end else begin
              rsp_bus.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Main stimulus: reset, directed corner cases, then random phases with config changes.
  initial begin : stimulus
    field_request_t directed[$];
    int             burst_left;
    periods = new();
    holds_asked = 0;
    burst_left = 0;
    rst                     <= 1'b1;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.shift_disable   <= 1'b0;
    req_bus.valid           <= 1'b0;
    req_bus.kind            <= KIND_SET_SHIFT;
    req_bus.channel         <= '0;
    req_bus.rate_residual   <= '0;
    req_bus.rate_divider    <= '0;
    req_bus.want_interlaced <= 1'b0;
    req_bus.shift_delta     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Smallest operands, then a scan-type change on the same channel.
    directed.push_back(make_request(KIND_SET_FIELD, 0, 32'd1, 32'd1, 1'b1, 32'd0));
    directed.push_back(make_request(KIND_SET_FIELD, 0, 32'd1, 32'd1, 1'b0, 32'd0));
    // Largest operands, and a quotient that overflows 32 bits.
    directed.push_back(make_request(KIND_SET_FIELD, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                    32'd0));
    directed.push_back(make_request(KIND_SET_FIELD, 2, 32'd1, 32'hFFFF_FFFF, 1'b0, 32'd0));
    // Zero residual, zero divider, and a bad channel that wins over both zeros.
    directed.push_back(make_request(KIND_SET_FIELD, 3, 32'd0, 32'd5, 1'b1, 32'd0));
    directed.push_back(make_request(KIND_SET_FIELD, 3, 32'd5, 32'd0, 1'b1, 32'd0));
    directed.push_back(make_request(KIND_SET_FIELD, 7, 32'd0, 32'd0, 1'b1, 32'd0));
    // Most negative and most positive shifts, each followed by a set_field on that channel.
    directed.push_back(make_request(KIND_SET_SHIFT, 2, 32'd0, 32'd0, 1'b0, 32'h8000_0000));
    directed.push_back(make_request(KIND_SET_FIELD, 2, 32'd27000000, 32'd1, 1'b0, 32'd0));
    directed.push_back(make_request(KIND_SET_SHIFT, 3, 32'd0, 32'd0, 1'b0, 32'h7FFF_FFFF));
    directed.push_back(make_request(KIND_SET_FIELD, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                    32'd0));
    // Bad channels on both kinds of transaction.
    directed.push_back(make_request(KIND_SET_SHIFT, 4, 32'd0, 32'd0, 1'b0, 32'd123));
    directed.push_back(make_request(KIND_SET_SHIFT, 6, 32'd0, 32'd0, 1'b1, 32'hFFFF_FFFB));
    directed.push_back(make_request(KIND_SET_FIELD, 4, 32'd1, 32'd1, 1'b1, 32'd0));
    // Shift of -1: totals of all ones, zero and one.
    directed.push_back(make_request(KIND_SET_SHIFT, 1, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    directed.push_back(make_request(KIND_SET_FIELD, 1, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'd0));
    directed.push_back(make_request(KIND_SET_FIELD, 1, 32'd27000000, 32'd1, 1'b0, 32'd0));
    directed.push_back(make_request(KIND_SET_FIELD, 1, 32'd13500000, 32'd1, 1'b0, 32'd0));
    foreach (directed[i]) offer(directed[i]);

    // With shifts disabled a set_shift must store zero.
    write_shift_disable(1'b1);
    directed.delete();
    directed.push_back(make_request(KIND_SET_SHIFT, 0, 32'd0, 32'd0, 1'b0, 32'd12345));
    directed.push_back(make_request(KIND_SET_FIELD, 0, 32'd1000, 32'd3000, 1'b1, 32'd0));
    directed.push_back(make_request(KIND_SET_SHIFT, 3, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    directed.push_back(make_request(KIND_SET_FIELD, 3, 32'd7, 32'd99, 1'b0, 32'd0));
    foreach (directed[i]) offer(directed[i]);
    write_shift_disable(1'b0);

    // Random phases: bursts of transactions with random gaps, one setting per phase.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        write_shift_disable(1'b1);
      end else if (phase == 1) begin
        write_shift_disable(1'b0);
      end else begin
        write_shift_disable(1'($urandom_range(0, 1)));
      end
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Ask the sink for a long hold-off in some phases while offers continue.
        if (n == PHASE_ITEMS / 2 && phase % 2 == 1) holds_asked++;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        burst_left--;
        offer(random_request());
      end
      req_bus.valid <= 1'b0;
    end

    // Wait out every response, then let the block settle before judging.
    req_bus.valid <= 1'b0;
    while (periods.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (periods.pending() != 0) begin
      $display("%0t: %0d expected responses never arrived", $time, periods.pending());
    end
    if (periods.mismatches == 0 && periods.pending() == 0) begin
      $display("tb_vsync_field_period_calc passed");
    end else begin
      $display("tb_vsync_field_period_calc failed");
    end
    $finish;
  end

endmodule
